### rtl/ean_pkg.sv
// Package for the e-mail address normaliser: character codes, parser phases and class decode.
`timescale 1ns / 1ps

package ean_pkg;

    localparam int CharWidth = 8;

    localparam logic [CharWidth-1:0] CHAR_AT     = 8'h40;  // '@'
    localparam logic [CharWidth-1:0] CHAR_DOT    = 8'h2E;  // '.'
    localparam logic [CharWidth-1:0] CHAR_PLUS   = 8'h2B;  // '+'
    localparam logic [CharWidth-1:0] CHAR_HYPHEN = 8'h2D;  // '-'
    localparam logic [CharWidth-1:0] CHAR_UNDER  = 8'h5F;  // '_'
    localparam logic [CharWidth-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CharWidth-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CharWidth-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [CharWidth-1:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [CharWidth-1:0] CHAR_LO_A   = 8'h61;
    localparam logic [CharWidth-1:0] CHAR_LO_Z   = 8'h7A;
    localparam logic [CharWidth-1:0] CASE_OFFSET = 8'h20;

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_LOCAL     = 5'b00001,
        PH_SKIP      = 5'b00010,
        PH_SLD       = 5'b00100,
        PH_TLD_EMPTY = 5'b01000,
        PH_TLD       = 5'b10000
    } phase_t;

    function automatic logic is_upper(input logic [CharWidth-1:0] c);
        return (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
    endfunction

    function automatic logic is_alnum(input logic [CharWidth-1:0] c);
        return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
               ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z)) || is_upper(c);
    endfunction

    function automatic logic [CharWidth-1:0] to_lower(input logic [CharWidth-1:0] c);
        return is_upper(c) ? (c + CASE_OFFSET) : c;
    endfunction

endpackage

### rtl/email_address_normalizer.sv
// E-mail address normaliser: checks an address byte by byte and forwards its normalised bytes.
`timescale 1ns / 1ps

//  Channel | Handshake                 | Payload
//  --------+---------------------------+------------------------------------------
//  input   | char_valid / char_stall   | char_in[7:0], is_last
//  result  | res_valid / res_stall     | norm_byte[7:0], emit, done_res, status
//
// Each item passes through an input register and then a result register. The
// input register takes the item when it is accepted, and the parser moves it
// into the result register once that register is free; its result is offered
// from there. One item can be taken in every cycle while no stall holds the
// result register; the rate is set by the single parser update that happens as an
// item moves from the input register to the result register. Reset returns the
// parser to the local part with no error and empties both registers. When the
// result register is full and stalled, the input register holds its item and
// char_stall rises only once that register is occupied as well.

module email_address_normalizer
    import ean_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 char_valid,
    output logic                 char_stall,
    input  logic [CharWidth-1:0] char_in,
    input  logic                 is_last,
    // result channel
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [CharWidth-1:0] norm_byte,
    output logic                 emit,
    output logic                 done_res,
    output logic                 status
);

    // Input register.
    logic                 in_valid_reg, in_valid_next;
    logic [CharWidth-1:0] in_char_reg;
    logic                 in_last_reg;

    // Parser state.
    phase_t phase_reg, phase_next;
    logic   error_reg, error_next;

    // Result register.
    logic                 res_valid_reg, res_valid_next;
    logic [CharWidth-1:0] byte_reg, byte_next;
    logic                 emit_reg, emit_next;
    logic                 done_reg;
    logic                 status_reg, status_next;

    logic res_free;
    logic advance;
    logic accept;

    // Working values for the parser step.
    phase_t               ph_step;
    logic                 err_step;
    logic                 emit_step;
    logic [CharWidth-1:0] byte_step;

    // The result register can take a new item when it is empty or being drained.
    assign res_free   = !res_valid_reg || !res_stall;
    assign advance    = in_valid_reg && res_free;
    assign char_stall = in_valid_reg && !res_free;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // One parser step on the byte in the input register.
    always_comb
    begin
        ph_step   = phase_reg;
        err_step  = error_reg;
        emit_step = 1'b0;
        byte_step = '0;
        if (!error_reg)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (in_char_reg == CHAR_AT)
                    begin
                        ph_step   = PH_SLD;
                        emit_step = 1'b1;
                        byte_step = in_char_reg;
                    end
                end
                PH_SLD:
                begin
                    if (in_char_reg == CHAR_DOT)
                    begin
                        ph_step = PH_TLD_EMPTY;
                    end
                    else if (is_alnum(in_char_reg) || (in_char_reg == CHAR_HYPHEN))
                    begin
                        emit_step = 1'b1;
                        byte_step = to_lower(in_char_reg);
                    end
                    else
                    begin
                        err_step = 1'b1;
                    end
                end
                PH_TLD_EMPTY, PH_TLD:
                begin
                    // Any byte here counts as a top-level domain byte, good or bad.
                    ph_step = PH_TLD;
                    if (is_alnum(in_char_reg) || (in_char_reg == CHAR_HYPHEN))
                    begin
                        emit_step = 1'b1;
                        byte_step = to_lower(in_char_reg);
                    end
                    else
                    begin
                        err_step = 1'b1;
                    end
                end
                default:
                begin
                    // Local part, and any code outside the one-hot set.
                    ph_step = PH_LOCAL;
                    if (in_char_reg == CHAR_AT)
                    begin
                        ph_step   = PH_SLD;
                        emit_step = 1'b1;
                        byte_step = in_char_reg;
                    end
                    else if (in_char_reg == CHAR_DOT)
                    begin
                        ph_step = PH_LOCAL;
                    end
                    else if (in_char_reg == CHAR_PLUS)
                    begin
                        ph_step = PH_SKIP;
                    end
                    else if (is_alnum(in_char_reg) || (in_char_reg == CHAR_UNDER) ||
                             (in_char_reg == CHAR_HYPHEN))
                    begin
                        emit_step = 1'b1;
                        byte_step = to_lower(in_char_reg);
                    end
                    else
                    begin
                        err_step = 1'b1;
                    end
                end
            endcase
        end
    end

    // The address is good only if it ends cleanly inside a non-empty top-level domain.
    always_comb
    begin
        phase_next  = phase_reg;
        error_next  = error_reg;
        byte_next   = byte_reg;
        emit_next   = emit_reg;
        status_next = status_reg;
        if (advance)
        begin
            byte_next   = byte_step;
            emit_next   = emit_step;
            status_next = in_last_reg && (err_step || (ph_step != PH_TLD));
            if (in_last_reg)
            begin
                phase_next = PH_LOCAL;
                error_next = 1'b0;
            end
            else
            begin
                phase_next = ph_step;
                error_next = err_step;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_free)
        begin
            res_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_LOCAL;
            error_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            phase_reg     <= phase_next;
            error_reg     <= error_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg <= char_in;
            in_last_reg <= is_last;
        end
        if (advance)
        begin
            done_reg <= in_last_reg;
        end
        byte_reg   <= byte_next;
        emit_reg   <= emit_next;
        status_reg <= status_next;
    end

    assign res_valid = res_valid_reg;
    assign norm_byte = byte_reg;
    assign emit      = emit_reg;
    assign done_res  = done_reg;
    assign status    = status_reg;

endmodule

### rtl/ean_checker.sv
// Port-level checks for the e-mail address normaliser, bound to its top level.
`timescale 1ns / 1ps

module ean_checker
    import ean_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 char_valid,
    input logic                 char_stall,
    input logic [CharWidth-1:0] char_in,
    input logic                 is_last,
    input logic                 res_valid,
    input logic                 res_stall,
    input logic [CharWidth-1:0] norm_byte,
    input logic                 emit,
    input logic                 done_res,
    input logic                 status
);

    // A result that forwards nothing carries a zero byte.
    a_quiet_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !emit) |-> (norm_byte == '0))
        else $error("result without emit carries a non-zero byte");

    // Forwarded bytes are never upper case.
    a_lower_case: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && emit) |-> ((norm_byte < CHAR_UP_A) || (norm_byte > CHAR_UP_Z)))
        else $error("forwarded byte is upper case");

    // Status is only raised on the final item of an address.
    a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !done_res) |-> !status)
        else $error("status raised on a result that is not final");

    // A stalled result holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=>
        (res_valid && $stable(norm_byte) && $stable(emit) &&
         $stable(done_res) && $stable(status)))
        else $error("stalled result changed");

    // A stalled input item is held by the sender.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_stall) |=>
        (char_valid && $stable(char_in) && $stable(is_last)))
        else $error("stalled input item changed");

endmodule

bind email_address_normalizer ean_checker u_ean_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_in    (char_in),
    .is_last    (is_last),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .norm_byte  (norm_byte),
    .emit       (emit),
    .done_res   (done_res),
    .status     (status)
);

### dv/email_address_normalizer_tb.sv
// Self-checking testbench for the e-mail address normaliser: directed table, then random addresses.
`timescale 1ns / 1ps

module email_address_normalizer_tb;
    import ean_pkg::*;

    // One result item as the block presents it on its result channel.
    typedef struct packed {
        logic [CharWidth-1:0] norm;
        logic                 emit;
        logic                 done;
        logic                 bad;
    } norm_res_t;

    // One row of the directed table. Where "typed" is set, the expected result
    // is written into the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic [CharWidth-1:0] ch;
        logic                 last;
        logic                 typed;
        norm_res_t            res;
    } dir_row_t;

    localparam norm_res_t QUIET   = '{8'h00, 1'b0, 1'b0, 1'b0};
    localparam norm_res_t BAD_END = '{8'h00, 1'b0, 1'b1, 1'b1};

    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 200000;

    // The directed part walks the extremes of the byte range, character classes
    // across the phases, skipping after a plus, empty local and second-level
    // parts, an empty top-level domain and the sticky error.
    localparam dir_row_t DIR_TBL [24] = '{
        '{8'h00,       1'b1, 1'b1, BAD_END},  // lowest byte alone: bad at once
        '{8'hFF,       1'b1, 1'b1, BAD_END},  // highest byte alone: not ASCII
        '{"Z",         1'b0, 1'b1, '{"z", 1'b1, 1'b0, 1'b0}},
        '{CHAR_UNDER,  1'b0, 1'b0, QUIET},
        '{CHAR_HYPHEN, 1'b0, 1'b0, QUIET},
        '{CHAR_DOT,    1'b0, 1'b1, QUIET},    // dots in the local part vanish
        '{"9",         1'b0, 1'b0, QUIET},
        '{CHAR_PLUS,   1'b0, 1'b1, QUIET},
        '{8'hFF,       1'b0, 1'b1, QUIET},    // anything goes while skipping
        '{CHAR_AT,     1'b0, 1'b1, '{CHAR_AT, 1'b1, 1'b0, 1'b0}},
        '{"A",         1'b0, 1'b0, QUIET},
        '{CHAR_DOT,    1'b0, 1'b1, QUIET},
        '{"C",         1'b1, 1'b0, QUIET},
        '{CHAR_AT,     1'b0, 1'b0, QUIET},    // empty local part
        '{CHAR_DOT,    1'b0, 1'b0, QUIET},    // empty second-level domain
        '{CHAR_HYPHEN, 1'b1, 1'b0, QUIET},
        '{"a",         1'b0, 1'b0, QUIET},
        '{CHAR_AT,     1'b0, 1'b0, QUIET},
        '{"b",         1'b0, 1'b0, QUIET},
        '{CHAR_DOT,    1'b1, 1'b0, QUIET},    // top-level domain left empty
        '{"!",         1'b0, 1'b1, QUIET},    // bad character raises the error
        '{CHAR_AT,     1'b0, 1'b1, QUIET},    // ignored once the error is set
        '{CHAR_DOT,    1'b0, 1'b1, QUIET},
        '{"z",         1'b1, 1'b1, BAD_END}
    };

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 char_valid = 1'b0;
    logic                 char_stall;
    logic [CharWidth-1:0] char_in    = '0;
    logic                 is_last    = 1'b0;
    logic                 res_valid;
    logic                 res_stall  = 1'b0;
    logic [CharWidth-1:0] norm_byte;
    logic                 emit;
    logic                 done_res;
    logic                 status;

    // Predictor state: the parser phase and the sticky error of the address in flight.
    phase_t    addr_phase = PH_LOCAL;
    logic      addr_err   = 1'b0;

    norm_res_t norm_due [$];  // expected results, oldest first
    int        mismatches = 0;
    int        items_sent = 0;
    int        cycles     = 0;
    bit        calm       = 1'b0;  // while set, neither side idles
    bit        drained    = 1'b0;

    email_address_normalizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_in    (char_in),
        .is_last    (is_last),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .norm_byte  (norm_byte),
        .emit       (emit),
        .done_res   (done_res),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic is_letter_digit(input logic [CharWidth-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [CharWidth-1:0] fold_case(input logic [CharWidth-1:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Works out the result of one accepted item and moves the parser state on.
    function automatic norm_res_t normalize_byte(input logic [CharWidth-1:0] c,
                                                 input logic last);
        norm_res_t r;
        logic      word;
        r    = QUIET;
        word = is_letter_digit(c) || c == CHAR_HYPHEN;
        if (!addr_err)
        begin
            case (addr_phase)
                PH_SKIP:
                begin
                    if (c == CHAR_AT)
                    begin
                        addr_phase = PH_SLD;
                        r.emit     = 1'b1;
                        r.norm     = c;
                    end
                end
                PH_SLD:
                begin
                    if (c == CHAR_DOT)
                        addr_phase = PH_TLD_EMPTY;
                    else if (word)
                    begin
                        r.emit = 1'b1;
                        r.norm = fold_case(c);
                    end
                    else
                        addr_err = 1'b1;
                end
                PH_TLD_EMPTY, PH_TLD:
                begin
                    addr_phase = PH_TLD;
                    if (word)
                    begin
                        r.emit = 1'b1;
                        r.norm = fold_case(c);
                    end
                    else
                        addr_err = 1'b1;
                end
                default:
                begin
                    addr_phase = PH_LOCAL;
                    if (c == CHAR_AT)
                    begin
                        addr_phase = PH_SLD;
                        r.emit     = 1'b1;
                        r.norm     = c;
                    end
                    else if (c == CHAR_PLUS)
                        addr_phase = PH_SKIP;
                    else if (word || c == CHAR_UNDER)
                    begin
                        r.emit = 1'b1;
                        r.norm = fold_case(c);
                    end
                    else if (c != CHAR_DOT)
                        addr_err = 1'b1;
                end
            endcase
        end
        r.done = last;
        if (last)
        begin
            r.bad      = addr_err || addr_phase != PH_TLD;
            addr_phase = PH_LOCAL;
            addr_err   = 1'b0;
        end
        return r;
    endfunction

    // Offers one item, with random idle cycles first, and records its expected
    // result once the block has taken it. Valid is lowered only for an idle
    // cycle, so it is never dropped and raised within the same edge.
    task automatic send_item(input logic [CharWidth-1:0] ch, input logic last,
                             input logic typed, input norm_res_t given);
        norm_res_t predicted;
        while (!calm && $urandom_range(99) < 27)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_in    <= ch;
        is_last    <= last;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        predicted = normalize_byte(ch, last);
        norm_due.push_back(typed ? given : predicted);
        items_sent++;
    endtask

    function automatic logic [CharWidth-1:0] any_alnum();
        case ($urandom_range(2))
            0:       return CHAR_ZERO + 8'($urandom_range(9));
            1:       return CHAR_UP_A + 8'($urandom_range(25));
            default: return CHAR_LO_A + 8'($urandom_range(25));
        endcase
    endfunction

    function automatic logic [CharWidth-1:0] word_char(input bit allow_under);
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return CHAR_HYPHEN;
        if (pick == 1 && allow_under)
            return CHAR_UNDER;
        return any_alnum();
    endfunction

    // Mostly any byte at all, otherwise the punctuation the parser cares about.
    function automatic logic [CharWidth-1:0] noise_byte();
        if ($urandom_range(3) != 0)
            return 8'($urandom_range(255));
        case ($urandom_range(4))
            0:       return CHAR_AT;
            1:       return CHAR_DOT;
            2:       return CHAR_PLUS;
            3:       return CHAR_HYPHEN;
            default: return CHAR_UNDER;
        endcase
    endfunction

    // Any byte but the at sign, as may follow a plus without ending the skip.
    function automatic logic [CharWidth-1:0] tag_byte();
        logic [CharWidth-1:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CHAR_AT);
        return b;
    endfunction

    // Sends one random address. Most are well formed with random content, so
    // that every phase is reached; some have one byte corrupted or no top-level
    // domain, and a few are plain noise.
    task automatic send_address();
        logic [CharWidth-1:0] addr [$];
        int                   kind;
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 8))
                addr.push_back(noise_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 6))
                addr.push_back(($urandom_range(5) == 0) ? CHAR_DOT : word_char(1'b1));
            if ($urandom_range(4) == 0)
            begin
                addr.push_back(CHAR_PLUS);
                repeat ($urandom_range(3))
                    addr.push_back(tag_byte());
            end
            addr.push_back(CHAR_AT);
            repeat ($urandom_range(0, 5))
                addr.push_back(word_char(1'b0));
            addr.push_back(CHAR_DOT);
            if ($urandom_range(9) != 0)
            begin
                repeat ($urandom_range(1, 4))
                    addr.push_back(word_char(1'b0));
            end
            if (kind >= 85)
                addr[$urandom_range(addr.size() - 1)] = noise_byte();
        end
        foreach (addr[i])
            send_item(addr[i], i == addr.size() - 1, 1'b0, QUIET);
    endtask

    // The receiver stalls at random, except during the calm stretch.
    always @(posedge clk)
        res_stall <= rst_n && !calm && ($urandom_range(99) < 27);

    // Each accepted result item is checked against the oldest expectation.
    always @(posedge clk)
    begin
        norm_res_t want;
        if (res_valid && !res_stall)
        begin
            if (norm_due.size() == 0)
            begin
                mismatches++;
                $error("result item with no input item outstanding");
            end
            else
            begin
                want = norm_due.pop_front();
                if (norm_byte !== want.norm)
                begin
                    mismatches++;
                    $error("norm_byte: expected %h, got %h", want.norm, norm_byte);
                end
                if (emit !== want.emit)
                begin
                    mismatches++;
                    $error("emit: expected %b, got %b", want.emit, emit);
                end
                if (done_res !== want.done)
                begin
                    mismatches++;
                    $error("done_res: expected %b, got %b", want.done, done_res);
                end
                if (status !== want.bad)
                begin
                    mismatches++;
                    $error("status: expected %b, got %b", want.bad, status);
                end
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIR_TBL[i])
            send_item(DIR_TBL[i].ch, DIR_TBL[i].last, DIR_TBL[i].typed, DIR_TBL[i].res);

        while (items_sent < RANDOM_ITEMS)
        begin
            calm = (items_sent >= 150 && items_sent < 230);
            // Once in the run the sender holds off until the pipeline is empty.
            if (!drained && items_sent >= 320)
            begin
                drained = 1'b1;
                char_valid <= 1'b0;
                do
                    @(posedge clk);
                while (norm_due.size() != 0);
            end
            send_address();
        end
        calm = 1'b0;
        char_valid <= 1'b0;

        while (norm_due.size() != 0)
            @(posedge clk);
        // Two register stages inside; the extra wait lets any stray result flush out.
        repeat (8)
            @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
